>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge, switched off while reset is applied
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every rising edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/irmap_pkg.sv
// ----------------------------------------------------------------------------
// irmap_pkg
// Types, widths, register indexes and status codes for the index remapper
// ----------------------------------------------------------------------------
package irmap_pkg;

  // default number of extra slots per table
  localparam int MAX_EXTRA_DEF = 256;

  // field widths
  localparam int NUM_W  = 32;
  localparam int KEY_W  = 31;
  localparam int BASE_W = 15;
  localparam int SLOT_W = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THING_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NULL_FRAME = 2'd2;

  // register reset values
  localparam logic [BASE_W-1:0] FRAME_BASE_RST = 15'd967;
  localparam logic [BASE_W-1:0] THING_BASE_RST = 15'd137;
  localparam logic [BASE_W-1:0] NULL_FRAME_RST = 15'd0;

  // result status codes
  typedef enum logic [2:0] {
    ST_PASS  = 3'd0,
    ST_FOUND = 3'd1,
    ST_NEW   = 3'd2,
    ST_NEG   = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  // input transaction
  typedef struct packed {
    logic              command;
    logic [NUM_W-1:0]  ext_number;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [2:0]        status;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_step;
    logic    finish;
    status_t kind;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic neg;
    logic below;
    logic empty;
    logic full;
    logic hit;
    logic last;
    logic out_busy;
  } dp_sts_t;

endpackage

>>> rtl/index_remap_allocate_on_miss_core.sv
// ----------------------------------------------------------------------------
// index_remap_allocate_on_miss_core
// Frame and thing number translation with allocate-on-miss
// ----------------------------------------------------------------------------
// One request is worked on at a time. A negative, pass-through or first-ever
// number goes from acceptance through the decide and finish states to the
// result register; a searched number also passes through the scan state,
// which examines stored keys in order up to a hit or the last key. The key
// scan reads one stored key per cycle through the single read port of the key
// memory. The result register lets a new request be accepted while the
// previous result still waits downstream. Configuration writes are always
// taken (cfg_ready is tied high) and must only be issued while idle.
module index_remap_allocate_on_miss_core #(
  parameter int MAX_EXTRA = irmap_pkg::MAX_EXTRA_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  irmap_pkg::in_t                  in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output irmap_pkg::out_t                 out_data,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [irmap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irmap_pkg::BASE_W-1:0]    cfg_data
);

  irmap_pkg::dp_cmd_t cmd;
  irmap_pkg::dp_sts_t sts;

  // register writes need no back-pressure
  assign cfg_ready = 1'b1;

  // sequencer
  irmap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  irmap_dp #(
    .MAX_EXTRA (MAX_EXTRA)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/irmap_ctrl.sv
// ----------------------------------------------------------------------------
// irmap_ctrl
// Sequencer: classifies a request, steps the key scan and issues the result
// ----------------------------------------------------------------------------
module irmap_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  irmap_pkg::dp_sts_t sts,
  output irmap_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t              state_r;
  irmap_pkg::status_t  kind_r;

  // one request in flight at a time
  assign in_stall = (state_r != S_IDLE);

  // commands to the datapath
  always_comb begin
    cmd            = '0;
    cmd.kind       = kind_r;
    cmd.load       = in_valid && (state_r == S_IDLE);
    cmd.scan_start = (state_r == S_DECIDE) && !sts.neg && !sts.below && !sts.empty;
    cmd.scan_step  = (state_r == S_SCAN) && !sts.hit && !sts.last;
    cmd.finish     = (state_r == S_FINISH) && !sts.out_busy;
  end

  // state and result kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= irmap_pkg::ST_PASS;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          priority if (sts.neg) begin
            kind_r  <= irmap_pkg::ST_NEG;
            state_r <= S_FINISH;
          end else if (sts.below) begin
            kind_r  <= irmap_pkg::ST_PASS;
            state_r <= S_FINISH;
          end else if (sts.empty) begin
            kind_r  <= irmap_pkg::ST_NEW;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // key read last cycle is compared now
          priority if (sts.hit) begin
            kind_r  <= irmap_pkg::ST_FOUND;
            state_r <= S_FINISH;
          end else if (sts.last) begin
            kind_r  <= sts.full ? irmap_pkg::ST_FULL : irmap_pkg::ST_NEW;
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!sts.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/irmap_dp.sv
// ----------------------------------------------------------------------------
// irmap_dp
// Datapath: configuration registers, key memories, counts and result register
// ----------------------------------------------------------------------------
module irmap_dp #(
  parameter int MAX_EXTRA = irmap_pkg::MAX_EXTRA_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  irmap_pkg::in_t                      in_data,
  input  logic                                cfg_we,
  input  logic [irmap_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irmap_pkg::BASE_W-1:0]        cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output irmap_pkg::out_t                     out_data,
  input  irmap_pkg::dp_cmd_t                  cmd,
  output irmap_pkg::dp_sts_t                  sts
);

  localparam int CNT_W = $clog2(MAX_EXTRA + 1);
  localparam int IDX_W = (MAX_EXTRA > 1) ? $clog2(MAX_EXTRA) : 1;

  // request registers
  logic                           cmd_r;
  logic [irmap_pkg::NUM_W-1:0]    num_r;

  // configuration
  logic [irmap_pkg::BASE_W-1:0]   frame_base_r;
  logic [irmap_pkg::BASE_W-1:0]   thing_base_r;
  logic [irmap_pkg::BASE_W-1:0]   null_frame_r;

  // table fill counts and scan position
  logic [CNT_W-1:0]               frame_cnt_r;
  logic [CNT_W-1:0]               thing_cnt_r;
  logic [CNT_W-1:0]               idx_r;
  logic [CNT_W-1:0]               idx_inc;

  // key memories
  logic [irmap_pkg::KEY_W-1:0]    frame_keys [MAX_EXTRA];
  logic [irmap_pkg::KEY_W-1:0]    thing_keys [MAX_EXTRA];
  logic [irmap_pkg::KEY_W-1:0]    rd_key_r;
  logic [IDX_W-1:0]               rd_addr;
  logic [IDX_W-1:0]               wr_addr;
  logic                           wr_en;

  // result
  logic                           out_valid_r;
  irmap_pkg::out_t                out_r;
  irmap_pkg::out_t                out_nxt;

  logic [irmap_pkg::BASE_W-1:0]   sel_base;
  logic [CNT_W-1:0]               sel_cnt;
  logic [CNT_W-1:0]               offset;
  logic [irmap_pkg::SLOT_W-1:0]   slot_sum;

  // table selection
  assign sel_base = cmd_r ? thing_base_r : frame_base_r;
  assign sel_cnt  = cmd_r ? thing_cnt_r  : frame_cnt_r;
  assign idx_inc  = idx_r + CNT_W'(1);

  // status towards the sequencer
  always_comb begin
    sts          = '0;
    sts.neg      = num_r[irmap_pkg::NUM_W-1];
    sts.below    = num_r < irmap_pkg::NUM_W'(sel_base);
    sts.empty    = (sel_cnt == '0);
    sts.full     = (sel_cnt == CNT_W'(MAX_EXTRA));
    sts.hit      = (rd_key_r == num_r[irmap_pkg::KEY_W-1:0]);
    sts.last     = (idx_inc == sel_cnt);
    sts.out_busy = out_valid_r && out_stall;
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_data.command;
      num_r <= in_data.ext_number;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= irmap_pkg::FRAME_BASE_RST;
      thing_base_r <= irmap_pkg::THING_BASE_RST;
      null_frame_r <= irmap_pkg::NULL_FRAME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irmap_pkg::REG_FRAME_BASE: frame_base_r <= cfg_data;
        irmap_pkg::REG_THING_BASE: thing_base_r <= cfg_data;
        irmap_pkg::REG_NULL_FRAME: null_frame_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_inc;
    end
  end

  // key memory read, one key per cycle
  assign rd_addr = cmd.scan_step ? idx_inc[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.scan_start || cmd.scan_step) begin
      rd_key_r <= cmd_r ? thing_keys[rd_addr] : frame_keys[rd_addr];
    end
  end

  // record a new key at the end of the table
  assign wr_en   = cmd.finish && (cmd.kind == irmap_pkg::ST_NEW);
  assign wr_addr = sel_cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en && !cmd_r) frame_keys[wr_addr] <= num_r[irmap_pkg::KEY_W-1:0];
    if (wr_en && cmd_r)  thing_keys[wr_addr] <= num_r[irmap_pkg::KEY_W-1:0];
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cnt_r <= '0;
      thing_cnt_r <= '0;
    end else if (wr_en) begin
      if (cmd_r) thing_cnt_r <= thing_cnt_r + CNT_W'(1);
      else       frame_cnt_r <= frame_cnt_r + CNT_W'(1);
    end
  end

  // slot arithmetic: base plus hit position or plus fill count
  assign offset   = (cmd.kind == irmap_pkg::ST_NEW) ? sel_cnt : idx_r;
  assign slot_sum = irmap_pkg::SLOT_W'(sel_base) + irmap_pkg::SLOT_W'(offset);

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = cmd.kind;
    unique case (cmd.kind)
      irmap_pkg::ST_PASS:  out_nxt.slot = num_r[irmap_pkg::SLOT_W-1:0];
      irmap_pkg::ST_FOUND: out_nxt.slot = slot_sum;
      irmap_pkg::ST_NEW:   out_nxt.slot = slot_sum;
      irmap_pkg::ST_NEG:   out_nxt.slot = cmd_r ? '0 : irmap_pkg::SLOT_W'(null_frame_r);
      irmap_pkg::ST_FULL:  out_nxt.slot = '0;
      default:             out_nxt.slot = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/irmap_chk.sv
// ----------------------------------------------------------------------------
// irmap_chk
// Port-level checks on the index remapper, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irmap_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input irmap_pkg::in_t                  in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input irmap_pkg::out_t                 out_data,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [irmap_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [irmap_pkg::BASE_W-1:0]    cfg_data
);

  // a stalled result transaction stays offered
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // a stalled result transaction keeps its payload
  `ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_data), "result changed while stalled")

  // reset leaves no result pending
  `ASSERT_CLK_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result pending after reset")

  // an accepted request blocks the next one from being taken at once
  `ASSERT_CLK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second request taken at once")

  // a full table answers with slot zero
  `ASSERT_CLK(a_full_slot, out_valid && (out_data.status == irmap_pkg::ST_FULL) |-> (out_data.slot == '0), "full table gave a slot")

endmodule

bind index_remap_allocate_on_miss_core irmap_chk u_chk (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame/thing index remapper
// ----------------------------------------------------------------------------
// Requests go in through a queue-fed driver and results are checked against a
// local model of both key tables as they leave. A short directed opening hits
// the negative, pass-through, hit and allocate paths and a base change after
// allocation. Random phases then reuse, allocate and fill both tables under
// several register settings, most with random idle bursts on both channels.
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = irmap_pkg::MAX_EXTRA_DEF;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int NUM_W  = irmap_pkg::NUM_W;
  localparam int KEY_W  = irmap_pkg::KEY_W;
  localparam int BASE_W = irmap_pkg::BASE_W;
  localparam int SLOT_W = irmap_pkg::SLOT_W;
  localparam int IDX_W  = irmap_pkg::CFG_IDX_W;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_THING = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  irmap_pkg::in_t       in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  irmap_pkg::out_t      out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [BASE_W-1:0]    cfg_data = '0;

  // local copy of registers and key tables, index 0 frames, 1 things
  logic [BASE_W-1:0] base_reg [2] = '{irmap_pkg::FRAME_BASE_RST, irmap_pkg::THING_BASE_RST};
  logic [BASE_W-1:0] null_frame_reg = irmap_pkg::NULL_FRAME_RST;
  logic [KEY_W-1:0]  key_tab [2][TABLE_DEPTH];
  int                key_cnt [2] = '{0, 0};

  irmap_pkg::in_t  pending_reqs [$];
  irmap_pkg::out_t pending_slots [$];
  irmap_pkg::in_t  issued_keys [$];

  bit              idle_on = 1'b1;
  int              gap_left = 0;
  int              stall_left = 0;
  bit              req_taken;
  irmap_pkg::out_t want;
  int              cfg_taken = 0;
  int              sent_cnt = 0;
  int              seen_cnt = 0;
  int              fail_cnt = 0;
  int              cycle_cnt = 0;
  int              stat_seen [5] = '{0, 0, 0, 0, 0};

  index_remap_allocate_on_miss_core #(
    .MAX_EXTRA (TABLE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // translate one number, allocating in the local table on a miss
  function automatic irmap_pkg::out_t remap_number(input irmap_pkg::in_t req);
    irmap_pkg::out_t   res;
    logic              tsel;
    logic [NUM_W-1:0]  num;
    logic [SLOT_W-1:0] base;
    int                hit_pos;
    tsel = req.command;
    num = req.ext_number;
    base = {1'b0, base_reg[tsel]};
    hit_pos = -1;
    res.slot = '0;
    res.status = irmap_pkg::ST_PASS;
    if (num[NUM_W-1]) begin
      res.slot = (tsel == CMD_THING) ? SLOT_W'(0) : {1'b0, null_frame_reg};
      res.status = irmap_pkg::ST_NEG;
    end else if (num < base) begin
      res.slot = num[SLOT_W-1:0];
    end else begin
      for (int i = 0; i < key_cnt[tsel]; i++)
        if (hit_pos < 0 && key_tab[tsel][i] == num[KEY_W-1:0]) hit_pos = i;
      if (hit_pos >= 0) begin
        res.slot = base + SLOT_W'(hit_pos);
        res.status = irmap_pkg::ST_FOUND;
      end else if (key_cnt[tsel] == TABLE_DEPTH) begin
        res.status = irmap_pkg::ST_FULL;
      end else begin
        key_tab[tsel][key_cnt[tsel]] = num[KEY_W-1:0];
        res.slot = base + SLOT_W'(key_cnt[tsel]);
        res.status = irmap_pkg::ST_NEW;
        key_cnt[tsel] = key_cnt[tsel] + 1;
      end
    end
    return res;
  endfunction

  // mostly small bases, now and then anywhere in range
  function automatic logic [BASE_W-1:0] random_base();
    if ($urandom_range(0, 7) == 0) return BASE_W'($urandom_range(1, 32767));
    return BASE_W'($urandom_range(1, 3000));
  endfunction

  // track register writes as they are taken
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        irmap_pkg::REG_FRAME_BASE: base_reg[CMD_FRAME] = cfg_data;
        irmap_pkg::REG_THING_BASE: base_reg[CMD_THING] = cfg_data;
        irmap_pkg::REG_NULL_FRAME: null_frame_reg = cfg_data;
        default: ;
      endcase
      cfg_taken = cfg_taken + 1;
    end
  end

  // request driver, predicts each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        pending_slots.push_back(remap_number(in_data));
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 7);
      end
      if (!in_valid || req_taken) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          sent_cnt = sent_cnt + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_slots.size() == 0) begin
          $error("unexpected result: slot %0d status %0d", out_data.slot, out_data.status);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = pending_slots.pop_front();
          seen_cnt = seen_cnt + 1;
          if (out_data.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, out_data.slot);
            fail_cnt = fail_cnt + 1;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status,
                   out_data.status);
            fail_cnt = fail_cnt + 1;
          end
          stat_seen[want.status] = stat_seen[want.status] + 1;
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 7);
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_req(input logic cmd, input logic [NUM_W-1:0] num);
    irmap_pkg::in_t req;
    req.command = cmd;
    req.ext_number = num;
    pending_reqs.push_back(req);
  endtask

  // wait until every request is in and every result is out
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || sent_cnt != seen_cnt)
      @(posedge clk);
  endtask

  // one register write, returns at the edge where it is taken
  task automatic cfg_send(input logic [IDX_W-1:0] idx, input logic [BASE_W-1:0] val);
    int seen;
    seen = cfg_taken;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    wait (cfg_taken != seen);
  endtask

  // write all three registers back to back, optionally poking the unused index
  task automatic write_regs(input logic [BASE_W-1:0] fb, input logic [BASE_W-1:0] tb,
                            input logic [BASE_W-1:0] nf, input bit poke);
    if (poke) cfg_send(REG_UNUSED, BASE_W'($urandom()));
    cfg_send(irmap_pkg::REG_FRAME_BASE, fb);
    cfg_send(irmap_pkg::REG_THING_BASE, tb);
    cfg_send(irmap_pkg::REG_NULL_FRAME, nf);
    cfg_valid <= 1'b0;
  endtask

  // random requests: negatives, extremes, pass-through, fresh keys and reuse
  task automatic queue_random(input int count, input int thing_pct, input int fresh_pct);
    irmap_pkg::in_t   req;
    logic [NUM_W-1:0] r;
    int unsigned      base;
    int               pick;
    for (int k = 0; k < count; k++) begin
      req.command = ($urandom_range(0, 99) < thing_pct) ? CMD_THING : CMD_FRAME;
      base = base_reg[req.command];
      r = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        req.ext_number = {1'b1, r[NUM_W-2:0]};
      end else if (pick < 7) begin
        case ($urandom_range(0, 3))
          0: req.ext_number = 32'h7FFF_FFFF;
          1: req.ext_number = base;
          2: req.ext_number = 32'hFFFF_FFFF;
          default: req.ext_number = 32'h8000_0000;
        endcase
      end else if (pick < 17 && base > 0) begin
        req.ext_number = $urandom_range(0, base - 1);
      end else if ($urandom_range(0, 99) < fresh_pct || issued_keys.size() == 0) begin
        if ($urandom_range(0, 1) == 1) req.ext_number = base + $urandom_range(0, 4095);
        else req.ext_number = {1'b0, r[NUM_W-2:0]};
        issued_keys.push_back(req);
      end else begin
        // reuse keeps the table the key was first sent to
        req = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
      end
      pending_reqs.push_back(req);
    end
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: negatives, base edges, first allocation, hits
    push_req(CMD_FRAME, 32'h8000_0000);
    push_req(CMD_THING, 32'hFFFF_FFFF);
    push_req(CMD_FRAME, 32'd0);
    push_req(CMD_FRAME, 32'd966);
    push_req(CMD_FRAME, 32'd967);
    push_req(CMD_FRAME, 32'd967);
    push_req(CMD_FRAME, 32'h7FFF_FFFF);
    push_req(CMD_THING, 32'd136);
    push_req(CMD_THING, 32'd137);
    push_req(CMD_THING, 32'h7FFF_FFFF);
    push_req(CMD_THING, 32'd137);
    push_req(CMD_FRAME, 32'h7FFF_FFFF);
    push_req(CMD_THING, 32'h7FFF_FFFF);
    wait_drained();

    // largest frame base, zero thing base, largest null frame
    write_regs(15'd32767, 15'd0, 15'd32767, 1'b1);
    push_req(CMD_FRAME, 32'h8000_0001);
    push_req(CMD_FRAME, 32'd967);
    push_req(CMD_FRAME, 32'h7FFF_FFFF);
    push_req(CMD_FRAME, 32'd32766);
    push_req(CMD_FRAME, 32'd32767);
    push_req(CMD_THING, 32'd0);
    push_req(CMD_THING, 32'd137);
    push_req(CMD_THING, 32'hC000_0000);
    push_req(CMD_THING, 32'h7FFF_FFFF);
    wait_drained();

    // mixed traffic
    write_regs(random_base(), random_base(), BASE_W'($urandom_range(0, 32767)), 1'b0);
    queue_random(200, 50, 30);
    wait_drained();

    // frame heavy, mostly new keys, fills the frame table
    write_regs(random_base(), random_base(), BASE_W'($urandom_range(0, 32767)), 1'b1);
    queue_random(380, 5, 85);
    wait_drained();

    // zero frame base, largest thing base, thing table fills
    write_regs(15'd0, 15'd32767, 15'd0, 1'b0);
    queue_random(350, 90, 95);
    wait_drained();

    // closing stretch without idling
    idle_on = 1'b0;
    write_regs(15'd1, random_base(), BASE_W'($urandom_range(0, 32767)), 1'b1);
    queue_random(200, 50, 30);
    wait_drained();

    repeat (TABLE_DEPTH + 8) @(posedge clk);
    $display("checked %0d pass-through, %0d hits, %0d allocations, %0d negative, %0d full",
             stat_seen[irmap_pkg::ST_PASS], stat_seen[irmap_pkg::ST_FOUND],
             stat_seen[irmap_pkg::ST_NEW], stat_seen[irmap_pkg::ST_NEG],
             stat_seen[irmap_pkg::ST_FULL]);
    $display("tables ended with %0d frame keys and %0d thing keys over six settings",
             key_cnt[CMD_FRAME], key_cnt[CMD_THING]);
    if (fail_cnt == 0 && pending_slots.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/irmap_pkg.sv
rtl/irmap_ctrl.sv
rtl/irmap_dp.sv
rtl/index_remap_allocate_on_miss_core.sv
rtl/irmap_chk.sv
dv/testbench.sv
